[hw/rtl/tlfq_pkg.sv]
// Shared types, codes and defaults for the three-level feedback queue.
// Used by tlfq_cell, tlfq_level and three_level_feedback_queue_top.
`default_nettype none

package tlfq_pkg;

   localparam int NUM_LEVELS       = 3;
   localparam int DEF_LEVEL_DEPTH  = 16;
   localparam int DEF_PID_BITS     = 16;
   localparam int DEF_PAYLOAD_BITS = 32;

   // Configuration register
   localparam int          CAP_W             = 5;
   localparam logic [4:0]  CAP_RESET         = 5'd16;
   localparam int          CSR_DATA_W        = 32;
   localparam int          CSR_ADDR_W        = 3;
   localparam logic        REG_LEVEL_CAPACITY = 1'b0;

   // Request codes
   typedef enum logic [1:0] {
      REQ_ADD     = 2'd0,
      REQ_GET     = 2'd1,
      REQ_PROMOTE = 2'd2,
      REQ_DEMOTE  = 2'd3
   } req_code_type;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_BADLEVEL = 2'd3;

   // Level numbers
   localparam logic [1:0] LVL_0       = 2'd0;
   localparam logic [1:0] LVL_1       = 2'd1;
   localparam logic [1:0] LVL_2       = 2'd2;
   localparam logic [1:0] LVL_INVALID = 2'd3;

   // Per-cell control
   typedef struct packed {
      logic capture;
      logic shift;
      logic load;
   } cell_ctrl_type;

   // Per-level control from the sequencer
   typedef struct packed {
      logic capture;
      logic pop;
      logic remove;
      logic push;
   } lvl_ctrl_type;

   // Per-level status to the sequencer
   typedef struct packed {
      logic found;
      logic empty;
   } lvl_stat_type;

endpackage

`default_nettype wire

[hw/rtl/tlfq_cell.sv]
// One storage cell of a queue level: identifier, payload and match flag.
// Depends on tlfq_pkg.
`default_nettype none

module tlfq_cell import tlfq_pkg::*; #(
   parameter int PID_BITS     = DEF_PID_BITS,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cell_ctrl_type           ctrl,
   input  wire logic                    valid,
   input  wire logic [PID_BITS-1:0]     search_pid,
   input  wire logic [PID_BITS-1:0]     new_pid,
   input  wire logic [PAYLOAD_BITS-1:0] new_pay,
   input  wire logic [PID_BITS-1:0]     next_pid,
   input  wire logic [PAYLOAD_BITS-1:0] next_pay,
   output logic      [PID_BITS-1:0]     pid,
   output logic      [PAYLOAD_BITS-1:0] pay,
   output logic                         hit
);

   logic [PID_BITS-1:0]     pid_ff, pid_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic                    hit_ff, hit_in;

   always_comb begin
      pid_in = pid_ff;
      pay_in = pay_ff;
      // take the neighbor's entry on a shift, else the new entry on a load
      if (ctrl.shift) begin
         pid_in = next_pid;
         pay_in = next_pay;
      end else if (ctrl.load) begin
         pid_in = new_pid;
         pay_in = new_pay;
      end
      hit_in = hit_ff;
      if (ctrl.capture) begin
         hit_in = valid && (pid_ff == search_pid);
      end
   end

   always_ff @(posedge clock) begin
      pid_ff <= pid_in;
      pay_ff <= pay_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign pid = pid_ff;
   assign pay = pay_ff;
   assign hit = hit_ff;

endmodule

`default_nettype wire

[hw/rtl/tlfq_level.sv]
// One queue level: a row of tlfq_cell, oldest entry in cell 0, plus fill count.
// Depends on tlfq_pkg and tlfq_cell.
`default_nettype none

module tlfq_level import tlfq_pkg::*; #(
   parameter int LEVEL_DEPTH  = DEF_LEVEL_DEPTH,
   parameter int PID_BITS     = DEF_PID_BITS,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
   parameter int CNT_W        = $clog2(LEVEL_DEPTH + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lvl_ctrl_type            ctrl,
   input  wire logic [PID_BITS-1:0]     search_pid,
   input  wire logic [PID_BITS-1:0]     new_pid,
   input  wire logic [PAYLOAD_BITS-1:0] new_pay,
   output lvl_stat_type                 stat,
   output logic      [CNT_W-1:0]        count,
   output logic      [PID_BITS-1:0]     head_pid,
   output logic      [PAYLOAD_BITS-1:0] head_pay
);

   localparam int STEPS = $clog2(LEVEL_DEPTH);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PID_BITS-1:0]     cell_pid [LEVEL_DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_pay [LEVEL_DEPTH];
   logic [LEVEL_DEPTH-1:0]  hits;
   logic [LEVEL_DEPTH-1:0]  pre [STEPS+1];

   // prefix OR of the match flags: every cell at or after the oldest match shifts
   always_comb begin
      pre[0] = hits;
      for (int s = 0; s < STEPS; s++) begin
         for (int i = 0; i < LEVEL_DEPTH; i++) begin
            if (i >= (1 << s)) begin
               pre[s+1][i] = pre[s][i] | pre[s][i - (1 << s)];
            end else begin
               pre[s+1][i] = pre[s][i];
            end
         end
      end
   end

   for (genvar i = 0; i < LEVEL_DEPTH; i++) begin : g_cell
      cell_ctrl_type           cctrl;
      logic [PID_BITS-1:0]     nxt_pid;
      logic [PAYLOAD_BITS-1:0] nxt_pay;

      if (i == LEVEL_DEPTH - 1) begin : g_last
         assign nxt_pid = '0;
         assign nxt_pay = '0;
      end else begin : g_mid
         assign nxt_pid = cell_pid[i+1];
         assign nxt_pay = cell_pay[i+1];
      end

      assign cctrl.capture = ctrl.capture;
      assign cctrl.shift   = ctrl.pop | (ctrl.remove & pre[STEPS][i]);
      assign cctrl.load    = ctrl.push && (count_ff == CNT_W'(i));

      tlfq_cell #(
         .PID_BITS     (PID_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cctrl),
         .valid      (count_ff > CNT_W'(i)),
         .search_pid (search_pid),
         .new_pid    (new_pid),
         .new_pay    (new_pay),
         .next_pid   (nxt_pid),
         .next_pay   (nxt_pay),
         .pid        (cell_pid[i]),
         .pay        (cell_pay[i]),
         .hit        (hits[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.pop || (ctrl.remove && pre[STEPS][LEVEL_DEPTH-1])) begin
         count_in = count_ff - CNT_W'(1);
      end else if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.found = pre[STEPS][LEVEL_DEPTH-1];
   assign stat.empty = (count_ff == '0);
   assign count      = count_ff;
   assign head_pid   = cell_pid[0];
   assign head_pay   = cell_pay[0];

endmodule

`default_nettype wire

[hw/rtl/three_level_feedback_queue_top.sv]
// Three-level feedback queue: top level with request sequencer and control register.
// Depends on tlfq_pkg and tlfq_level (which holds the rows of tlfq_cell).
//
// Usage:
//   Requests enter on the req_ channel (valid/ready) and each one yields exactly one
//   response on the rsp_ channel (valid/ready). Request codes: add to a level, get the
//   oldest entry of the highest non-empty level, promote an identifier to level 0,
//   demote an identifier one level down.
//   Each level is a row of cells, oldest entry in cell 0. On acceptance every cell
//   compares its identifier against the request in parallel (S_IDLE); in S_EXEC, once
//   the output register is free, the rows shift (pop or gap closing), the new entry is
//   written after the last valid cell and the response is registered. A new request is
//   taken only after the previous one has left S_EXEC.
//   The response sits in an output register; req_ready rises again as soon as the
//   response is loaded, so a new request may be accepted while the response waits.
//   If rsp_ready is low when the next response is due, the block holds it in the
//   shift cycle until the output register frees up.
//   Reset (synchronous, active high) empties all levels and sets level_capacity to 16.
//   level_capacity lives at byte address 0 of the csr_ port; write it only while idle.
`default_nettype none

module three_level_feedback_queue_top import tlfq_pkg::*; #(
   parameter int LEVEL_DEPTH  = DEF_LEVEL_DEPTH,
   parameter int PID_BITS     = DEF_PID_BITS,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_type,
   input  wire logic [1:0]              req_target_level,
   input  wire logic [PID_BITS-1:0]     req_entry_pid,
   input  wire logic [PAYLOAD_BITS-1:0] req_entry_payload,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [1:0]              rsp_status,
   output logic      [PID_BITS-1:0]     rsp_out_pid,
   output logic      [PAYLOAD_BITS-1:0] rsp_out_payload,
   output logic      [1:0]              rsp_out_level,
   // configuration port
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [CSR_DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // sequencer state and the held request
   state_type               state_ff, state_in;
   logic [1:0]              rq_type_ff, rq_type_in;
   logic [1:0]              rq_level_ff, rq_level_in;
   logic [PID_BITS-1:0]     rq_pid_ff, rq_pid_in;
   logic [PAYLOAD_BITS-1:0] rq_pay_ff, rq_pay_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [PID_BITS-1:0]     rsp_pid_ff, rsp_pid_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;
   logic [1:0]              rsp_level_ff, rsp_level_in;

   // configuration
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic [CMP_W-1:0]        eff_cap;
   logic                    csr_write;

   // level interface
   lvl_ctrl_type            lvl_ctrl  [NUM_LEVELS];
   lvl_stat_type            lvl_stat  [NUM_LEVELS];
   logic [CNT_W-1:0]        lvl_count [NUM_LEVELS];
   logic [PID_BITS-1:0]     lvl_hpid  [NUM_LEVELS];
   logic [PAYLOAD_BITS-1:0] lvl_hpay  [NUM_LEVELS];
   logic [NUM_LEVELS-1:0]   lvl_full;
   logic                    accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // ---------------------------------------------------------------------------
   // Configuration register: write on the access phase, read back anytime
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_write && (csr_paddr[2] == REG_LEVEL_CAPACITY)) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_LEVEL_CAPACITY) ?
                       CSR_DATA_W'(cap_ff) : '0;

   // clamp capacity into 1..LEVEL_DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(LEVEL_DEPTH)) begin
         eff_cap = CMP_W'(LEVEL_DEPTH);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // Levels
   // ---------------------------------------------------------------------------
   for (genvar k = 0; k < NUM_LEVELS; k++) begin : g_level
      tlfq_level #(
         .LEVEL_DEPTH  (LEVEL_DEPTH),
         .PID_BITS     (PID_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS),
         .CNT_W        (CNT_W)
      ) u_level (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lvl_ctrl[k]),
         .search_pid (req_entry_pid),
         .new_pid    (rq_pid_ff),
         .new_pay    (rq_pay_ff),
         .stat       (lvl_stat[k]),
         .count      (lvl_count[k]),
         .head_pid   (lvl_hpid[k]),
         .head_pay   (lvl_hpay[k])
      );

      assign lvl_full[k] = (CMP_W'(lvl_count[k]) >= eff_cap);
   end

   // ---------------------------------------------------------------------------
   // Sequencer
   //   S_IDLE: accept a request; every cell latches its match flag against it.
   //   S_EXEC: apply pop / removal / append and load the response register.
   // ---------------------------------------------------------------------------
   always_comb begin
      logic [1:0] push_lvl;
      logic       do_push;

      push_lvl      = LVL_0;
      do_push       = 1'b0;
      state_in      = state_ff;
      rq_type_in    = rq_type_ff;
      rq_level_in   = rq_level_ff;
      rq_pid_in     = rq_pid_ff;
      rq_pay_in     = rq_pay_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_level_in  = rsp_level_ff;

      for (int k = 0; k < NUM_LEVELS; k++) begin
         lvl_ctrl[k]         = '0;
         lvl_ctrl[k].capture = accept;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // capture the request; match flags latch in the cells
               rq_type_in  = req_type;
               rq_level_in = req_target_level;
               rq_pid_in   = req_entry_pid;
               rq_pay_in   = req_entry_payload;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // advance only once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_pid_in    = '0;
               rsp_pay_in    = '0;
               rsp_level_in  = LVL_0;

               unique case (rq_type_ff)
                  REQ_ADD: begin
                     if (rq_level_ff == LVL_INVALID) begin
                        rsp_status_in = ST_BADLEVEL;
                     end else begin
                        do_push  = 1'b1;
                        push_lvl = rq_level_ff;
                     end
                  end
                  REQ_GET: begin
                     // pop from the highest non-empty level
                     if (!lvl_stat[0].empty) begin
                        lvl_ctrl[0].pop = 1'b1;
                        rsp_pid_in      = lvl_hpid[0];
                        rsp_pay_in      = lvl_hpay[0];
                        rsp_level_in    = LVL_0;
                     end else if (!lvl_stat[1].empty) begin
                        lvl_ctrl[1].pop = 1'b1;
                        rsp_pid_in      = lvl_hpid[1];
                        rsp_pay_in      = lvl_hpay[1];
                        rsp_level_in    = LVL_1;
                     end else if (!lvl_stat[2].empty) begin
                        lvl_ctrl[2].pop = 1'b1;
                        rsp_pid_in      = lvl_hpid[2];
                        rsp_pay_in      = lvl_hpay[2];
                        rsp_level_in    = LVL_2;
                     end else begin
                        rsp_status_in = ST_EMPTY;
                     end
                  end
                  REQ_PROMOTE: begin
                     // drop the match from level 1, append to level 0 regardless
                     lvl_ctrl[1].remove = lvl_stat[1].found;
                     do_push            = 1'b1;
                     push_lvl           = LVL_0;
                  end
                  REQ_DEMOTE: begin
                     if (lvl_stat[0].found) begin
                        lvl_ctrl[0].remove = 1'b1;
                        push_lvl           = LVL_1;
                     end else begin
                        lvl_ctrl[1].remove = lvl_stat[1].found;
                        push_lvl           = LVL_2;
                     end
                     do_push = 1'b1;
                  end
               endcase

               // append to the chosen level unless it is at capacity
               if (do_push) begin
                  for (int k = 0; k < NUM_LEVELS; k++) begin
                     if (push_lvl == 2'(k)) begin
                        if (lvl_full[k]) begin
                           rsp_status_in = ST_FULL;
                        end else begin
                           lvl_ctrl[k].push = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rq_type_ff    <= rq_type_in;
      rq_level_ff   <= rq_level_in;
      rq_pid_ff     <= rq_pid_in;
      rq_pay_ff     <= rq_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_level_ff  <= rsp_level_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_pid     = rsp_pid_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_out_level   = rsp_level_ff;

endmodule

`default_nettype wire
